### hdl/akrt_pkg.sv
// ---------------------------------------------------------------------------
// akrt_pkg: shared types and constants for the rapid trigger key block
// Register indexes, reset values, field widths and the structs that carry
// key settings and per-key state between modules.
// ---------------------------------------------------------------------------
package akrt_pkg;

  localparam int IDX_W  = 6;
  localparam int POS_W  = 8;
  localparam int DMM_W  = 7;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 7;

  // Wide enough for 127 * 4 + 255.
  localparam int THR_W = 10;

  localparam logic [THR_W-1:0] RELEASE_OFFSET = THR_W'(2);

  localparam logic [CFG_AW-1:0] REG_USE_PER_KEY    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_GLOBAL_ACT     = 3'd1;
  localparam logic [CFG_AW-1:0] REG_GLOBAL_RAPID   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_GLOBAL_PSENS   = 3'd3;
  localparam logic [CFG_AW-1:0] REG_GLOBAL_RSENS   = 3'd4;

  localparam logic             RST_USE_PER_KEY  = 1'b0;
  localparam logic [DMM_W-1:0] RST_GLOBAL_ACT   = 7'd20;
  localparam logic             RST_GLOBAL_RAPID = 1'b0;
  localparam logic [DMM_W-1:0] RST_GLOBAL_PSENS = 7'd2;
  localparam logic [DMM_W-1:0] RST_GLOBAL_RSENS = 7'd2;

  typedef struct packed {
    logic [DMM_W-1:0] actuation;
    logic             rapid;
    logic [DMM_W-1:0] press_sens;
    logic [DMM_W-1:0] release_sens;
  } key_settings_t;

  typedef struct packed {
    logic             pressed;
    logic [POS_W-1:0] extreme;
  } key_state_t;

  localparam int STATE_W = $bits(key_state_t);

endpackage

### hdl/akrt_ram.sv
// ---------------------------------------------------------------------------
// akrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; the read returns the old
// contents when both touch the same address.
// ---------------------------------------------------------------------------
module akrt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hdl/akrt_decide.sv
// ---------------------------------------------------------------------------
// akrt_decide: press/release decision for one key reading
// Combines the key's stored state, its settings and the new position into
// the next stored state, in plain hysteresis or rapid trigger mode.
// ---------------------------------------------------------------------------
module akrt_decide
  import akrt_pkg::*;
#(
  parameter int STEPS_PER_DMM = 2
) (
  input  logic [POS_W-1:0] position,
  input  key_settings_t    settings,
  input  key_state_t       cur,
  output key_state_t       nxt
);

  localparam logic [THR_W-1:0] STEPS = THR_W'(STEPS_PER_DMM);

  logic [THR_W-1:0] act_pt;
  logic [THR_W-1:0] rel_pt;
  logic [THR_W-1:0] press_steps;
  logic [THR_W-1:0] release_steps;
  logic [THR_W-1:0] pos_w;
  logic [THR_W-1:0] ext_w;
  logic             rel_wrap;
  logic             pos_at_rel;
  logic             ext_at_rel;
  logic             reached_act;
  logic             rapid_release;
  logic             rapid_press;

  always_comb begin
    act_pt        = THR_W'(settings.actuation) * STEPS;
    press_steps   = THR_W'(settings.press_sens) * STEPS;
    release_steps = THR_W'(settings.release_sens) * STEPS;
    rel_pt        = act_pt - RELEASE_OFFSET;
    pos_w         = THR_W'(position);
    ext_w         = THR_W'(cur.extreme);

    // A release point below zero wraps above every position.
    rel_wrap    = act_pt < RELEASE_OFFSET;
    pos_at_rel  = rel_wrap || (pos_w <= rel_pt);
    ext_at_rel  = rel_wrap || (ext_w <= rel_pt);
    reached_act = pos_w >= act_pt;

    rapid_release = ((pos_w + release_steps) <= ext_w) || pos_at_rel;
    rapid_press   = reached_act && (ext_at_rel || (pos_w >= (ext_w + press_steps)));

    nxt = cur;
    if (settings.rapid) begin
      if (cur.pressed) begin
        if (rapid_release) begin
          nxt.pressed = 1'b0;
          nxt.extreme = position;
        end else if (position > cur.extreme) begin
          nxt.extreme = position;
        end
      end else begin
        if (rapid_press) begin
          nxt.pressed = 1'b1;
          nxt.extreme = position;
        end else if (position < cur.extreme) begin
          nxt.extreme = position;
        end
      end
    end else begin
      nxt.pressed = cur.pressed ? !pos_at_rel : reached_act;
    end
  end

endmodule

### hdl/analog_key_rapid_trigger_top.sv
// Rapid trigger decision for analog keys: each word on the input channel is one
// reading of one key, and exactly one word comes back on the output channel with
// the key's new pressed state, in order. A reading can be taken every cycle while
// the output is not held by out_ready. Both the reading and its result are
// registered, in the input and state read stage and the output register. This is
// because the per-key state (pressed flag and travel extreme) lives in a RAM
// with a registered read, and the decision is registered before it leaves.
// Back-to-back readings of the same key are forwarded around the RAM. Per-key
// state is clear right after reset with no clearing pass, and readings for keys
// at or above NUM_KEYS return released without touching any state.
// ---------------------------------------------------------------------------
// analog_key_rapid_trigger_top: analog key rapid trigger top level
// Input and state read stage, decision logic and output register, plus the
// configuration registers for the global key settings.
// ---------------------------------------------------------------------------
module analog_key_rapid_trigger_top
  import akrt_pkg::*;
#(
  parameter int NUM_KEYS      = 64,
  parameter int STEPS_PER_DMM = 2
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              cfg_write,
  input  logic [CFG_AW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,

  input  logic              in_valid,
  output logic              in_ready,
  input  logic [IDX_W-1:0]  key_index,
  input  logic [POS_W-1:0]  key_position,
  input  logic [DMM_W-1:0]  key_actuation_dmm,
  input  logic              key_rapid_enable,
  input  logic [DMM_W-1:0]  key_press_sens_dmm,
  input  logic [DMM_W-1:0]  key_release_sens_dmm,

  output logic              out_valid,
  input  logic              out_ready,
  output logic              pressed
);

  localparam int AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic [8:0] NK = 9'(NUM_KEYS);

  // Configuration registers.
  logic             use_per_key;
  logic [DMM_W-1:0] global_act;
  logic             global_rapid;
  logic [DMM_W-1:0] global_psens;
  logic [DMM_W-1:0] global_rsens;

  // Input and state read stage.
  logic             s1_valid;
  logic             s1_in_range;
  logic [AW-1:0]    s1_addr;
  logic [POS_W-1:0] s1_position;
  key_settings_t    s1_key_set;
  logic             s1_entry_valid;
  logic             fwd_hit;
  key_state_t       fwd_state;

  logic             in_fire;
  logic             s1_adv;
  logic             in_range;
  logic [7:0]       idx_wide;
  logic [AW-1:0]    in_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [STATE_W-1:0] ram_rdata;
  key_state_t       cur_state;
  key_state_t       nxt_state;
  key_settings_t    s1_set;
  logic             pressed_next;

  logic [NUM_KEYS-1:0] key_valid;

  assign idx_wide = 8'(key_index);
  assign in_addr  = idx_wide[AW-1:0];
  assign in_range = {3'b000, key_index} < NK;

  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign in_fire  = in_valid && in_ready;

  assign wr_en   = s1_valid && s1_adv && s1_in_range;
  assign wr_addr = s1_addr;

  always_comb begin
    if (fwd_hit) begin
      cur_state = fwd_state;
    end else if (s1_entry_valid) begin
      cur_state = key_state_t'(ram_rdata);
    end else begin
      cur_state = '0;
    end
  end

  always_comb begin
    if (use_per_key) begin
      s1_set = s1_key_set;
    end else begin
      s1_set.actuation    = global_act;
      s1_set.rapid        = global_rapid;
      s1_set.press_sens   = global_psens;
      s1_set.release_sens = global_rsens;
    end
  end

  assign pressed_next = s1_in_range && nxt_state.pressed;

  akrt_ram #(
    .WIDTH (STATE_W),
    .DEPTH (NUM_KEYS),
    .ADDR_W(AW)
  ) u_state_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(nxt_state),
    .rd_en  (in_fire),
    .rd_addr(in_addr),
    .rd_data(ram_rdata)
  );

  akrt_decide #(
    .STEPS_PER_DMM(STEPS_PER_DMM)
  ) u_decide (
    .position(s1_position),
    .settings(s1_set),
    .cur     (cur_state),
    .nxt     (nxt_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      use_per_key  <= RST_USE_PER_KEY;
      global_act   <= RST_GLOBAL_ACT;
      global_rapid <= RST_GLOBAL_RAPID;
      global_psens <= RST_GLOBAL_PSENS;
      global_rsens <= RST_GLOBAL_RSENS;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_USE_PER_KEY:  use_per_key  <= cfg_data[0];
        REG_GLOBAL_ACT:   global_act   <= cfg_data;
        REG_GLOBAL_RAPID: global_rapid <= cfg_data[0];
        REG_GLOBAL_PSENS: global_psens <= cfg_data;
        REG_GLOBAL_RSENS: global_rsens <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      fwd_hit   <= 1'b0;
      key_valid <= '0;
    end else begin
      if (in_fire) begin
        s1_valid <= 1'b1;
        // The RAM read misses a write to the same key at this edge.
        fwd_hit  <= wr_en && (wr_addr == in_addr);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
      if (wr_en) begin
        key_valid[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_in_range             <= in_range;
      s1_addr                 <= in_addr;
      s1_position             <= key_position;
      s1_key_set.actuation    <= key_actuation_dmm;
      s1_key_set.rapid        <= key_rapid_enable;
      s1_key_set.press_sens   <= key_press_sens_dmm;
      s1_key_set.release_sens <= key_release_sens_dmm;
      s1_entry_valid          <= in_range && key_valid[in_addr];
      fwd_state               <= nxt_state;
    end
    if (s1_valid && s1_adv) begin
      pressed <= pressed_next;
    end
  end

`ifndef SYNTH
  a_out_of_range_released: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_adv && !s1_in_range) |=> (out_valid && !pressed))
    else $error("key beyond range did not report released");

  a_full_stalls_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are held");

  a_written_entry_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> key_valid[$past(wr_addr)])
    else $error("written key state not marked valid");

  a_plain_keeps_extreme: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !s1_set.rapid) |-> (nxt_state.extreme == cur_state.extreme))
    else $error("plain mode changed the stored extreme");
`endif

endmodule
